>>> rtl/ipk_pkg.sv
// Package for the inverse Park / Clarke / SVPWM block: widths, constants, sine table, control types.
package ipk_pkg;

    // Field widths
    localparam int ANGLE_BITS = 12;
    localparam int VOLT_BITS  = 16;

    // Quarter-wave sine table geometry
    localparam int QTR_BITS  = ANGLE_BITS - 2;
    localparam int QUARTER   = 1 << QTR_BITS;
    localparam int ROM_DEPTH = QUARTER + 1;
    localparam int IDX_W     = QTR_BITS + 1;
    localparam int ROM_W     = 15;                 // Q1.14 magnitude, 0..16384

    // Datapath widths
    localparam int SIN_W   = ROM_W + 1;            // signed sine / cosine
    localparam int PROD_W  = SIN_W + VOLT_BITS;    // sine * volt
    localparam int SUM_W   = PROD_W + 1;           // two products added
    localparam int ALPHA_W = SUM_W - 14;           // alpha / beta at Q2.14 scale
    localparam int K_W     = 17;                   // signed width of sqrt(3)/2 in Q16
    localparam int BK_W    = ALPHA_W + K_W;
    localparam int PH_W    = ALPHA_W + 18;         // phases at scale 2^16
    localparam int MM_W    = PH_W + 1;             // max + min
    localparam int FIN_W   = PH_W + 2;             // 2p - (max + min)
    localparam int Q_W     = FIN_W - 17;           // after the final rounding shift

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [K_W-1:0] SQRT3_HALF = 17'sd56756;

    // Taylor series divisors, (2n)(2n+1) for terms 1 to 9
    localparam longint unsigned TAYLOR_DIV [1:9] = '{
        64'd2 * 64'd3,   64'd4 * 64'd5,   64'd6 * 64'd7,
        64'd8 * 64'd9,   64'd10 * 64'd11, 64'd12 * 64'd13,
        64'd14 * 64'd15, 64'd16 * 64'd17, 64'd18 * 64'd19
    };

    // Stage enables for the rotation part of the pipe
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_park_ctl;

    typedef logic [ROM_W-1:0] t_sin_rom [ROM_DEPTH];

    // Table contents: Q2.30 Taylor series of sin, rounded half up to Q1.14
    function automatic t_sin_rom build_sin_rom();
        t_sin_rom          rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            acc;
        int                k;
        int                n;
        for (k = 0; k < ROM_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * longint'(k) + longint'(QUARTER / 2)) / QUARTER;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (n = 1; n <= 9; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            rom[k] = ROM_W'((longint'(acc) + 32768) >>> 16);
        end
        return rom;
    endfunction

    localparam t_sin_rom SIN_ROM = build_sin_rom();

endpackage

>>> rtl/ipk_if.sv
// Valid/ready stream interfaces for the command and phase channels.
interface ipk_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ipk_pkg::VOLT_BITS-1:0]  volt_q;
    logic signed [ipk_pkg::VOLT_BITS-1:0]  volt_d;
    logic        [ipk_pkg::ANGLE_BITS-1:0] rotor_angle;

    modport source (output valid, output volt_q, output volt_d, output rotor_angle,
                    input ready);
    modport sink   (input valid, input volt_q, input volt_d, input rotor_angle,
                    output ready);
endinterface

interface ipk_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ipk_pkg::VOLT_BITS-1:0] phase_a;
    logic signed [ipk_pkg::VOLT_BITS-1:0] phase_b;
    logic signed [ipk_pkg::VOLT_BITS-1:0] phase_c;

    modport source (output valid, output phase_a, output phase_b, output phase_c,
                    input ready);
    modport sink   (input valid, input phase_a, input phase_b, input phase_c,
                    output ready);
endinterface

>>> rtl/inverse_park_svpwm.sv
// Top level: inverse Park, inverse Clarke and min-max zero-sequence injection.
//
// Takes one beat of (volt_q, volt_d, rotor_angle) per clock and returns one beat of
// (phase_a, phase_b, phase_c) for each, all Q2.14 and saturated. The pipe
// has seven register stages: table read, sine/cosine products, rotation, the
// sqrt(3)/2 product, phase forming, max/min, and final rounding with saturation.
// Sine and cosine come from a 1025-entry quarter-wave table read on two ports at
// once. Each stage holds its beat only while the stage after it is full and held,
// so empty slots still fill while the output waits, and throughput is one beat per
// cycle whenever the sink takes results every cycle.
module inverse_park_svpwm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ipk_in_if.sink           i_in,
    ipk_out_if.source        o_out
);

    localparam int NSTG   = 7;
    localparam int SUM3_W = ipk_pkg::PH_W + 2;
    localparam logic signed [ipk_pkg::FIN_W-1:0] RND17 = ipk_pkg::FIN_W'(1 << 16);
    localparam logic signed [ipk_pkg::Q_W-1:0] QMAX =
        ipk_pkg::Q_W'((1 << (ipk_pkg::VOLT_BITS - 1)) - 1);
    localparam logic signed [ipk_pkg::Q_W-1:0] QMIN = -QMAX - ipk_pkg::Q_W'(1);

    logic [NSTG:1]    r_vld;
    logic [NSTG+1:1]  n_en;
    logic [NSTG:1]    n_stall;
    ipk_pkg::t_park_ctl n_park_ctl;

    logic signed [ipk_pkg::ALPHA_W-1:0] n_alpha;
    logic signed [ipk_pkg::ALPHA_W-1:0] n_beta;

    logic signed [ipk_pkg::ALPHA_W-1:0] r_alpha4;
    logic signed [ipk_pkg::BK_W-1:0]    r_bk;

    logic signed [ipk_pkg::PH_W-1:0]    n_ah;
    logic signed [ipk_pkg::PH_W-1:0]    r5_pa;
    logic signed [ipk_pkg::PH_W-1:0]    r5_pb;
    logic signed [ipk_pkg::PH_W-1:0]    r5_pc;

    logic signed [ipk_pkg::PH_W-1:0]    n_mx;
    logic signed [ipk_pkg::PH_W-1:0]    n_mn;
    logic signed [ipk_pkg::PH_W-1:0]    r6_pa;
    logic signed [ipk_pkg::PH_W-1:0]    r6_pb;
    logic signed [ipk_pkg::PH_W-1:0]    r6_pc;
    logic signed [ipk_pkg::MM_W-1:0]    r6_mm;

    logic signed [ipk_pkg::FIN_W-1:0]   n_fa;
    logic signed [ipk_pkg::FIN_W-1:0]   n_fb;
    logic signed [ipk_pkg::FIN_W-1:0]   n_fc;
    logic signed [ipk_pkg::Q_W-1:0]     n_qa;
    logic signed [ipk_pkg::Q_W-1:0]     n_qb;
    logic signed [ipk_pkg::Q_W-1:0]     n_qc;
    logic signed [ipk_pkg::VOLT_BITS-1:0] r_pha;
    logic signed [ipk_pkg::VOLT_BITS-1:0] r_phb;
    logic signed [ipk_pkg::VOLT_BITS-1:0] r_phc;

    function automatic logic signed [ipk_pkg::VOLT_BITS-1:0] sat_volt(
        input logic signed [ipk_pkg::Q_W-1:0] v
    );
        logic signed [ipk_pkg::VOLT_BITS-1:0] res;
        priority if (v > QMAX) begin
            res = ipk_pkg::VOLT_BITS'(QMAX);
        end else if (v < QMIN) begin
            res = ipk_pkg::VOLT_BITS'(QMIN);
        end else begin
            res = ipk_pkg::VOLT_BITS'(v);
        end
        return res;
    endfunction

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        n_en[NSTG+1] = o_out.ready;
        for (int k = NSTG; k >= 1; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
        n_stall    = r_vld & ~n_en[NSTG:1];
        n_park_ctl = '{en1: n_en[1], en2: n_en[2], en3: n_en[3]};
    end

    assign i_in.ready = n_en[1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stages 1 to 3
    ipk_park u_park (
        .i_clk    (i_clk),
        .i_ctl    (n_park_ctl),
        .i_volt_q (i_in.volt_q),
        .i_volt_d (i_in.volt_d),
        .i_angle  (i_in.rotor_angle),
        .o_alpha  (n_alpha),
        .o_beta   (n_beta)
    );

    // Stage 4: beta times sqrt(3)/2
    always_ff @(posedge i_clk) begin
        if (n_en[4]) begin
            r_alpha4 <= n_alpha;
            r_bk     <= n_beta * ipk_pkg::SQRT3_HALF;
        end
    end

    // Stage 5: inverse Clarke at scale 2^16
    assign n_ah = ipk_pkg::PH_W'(r_alpha4) <<< 15;

    always_ff @(posedge i_clk) begin
        if (n_en[5]) begin
            r5_pa <= ipk_pkg::PH_W'(r_alpha4) <<< 16;
            r5_pb <= ipk_pkg::PH_W'(r_bk) - n_ah;
            r5_pc <= -n_ah - ipk_pkg::PH_W'(r_bk);
        end
    end

    // Stage 6: largest plus smallest phase
    always_comb begin
        n_mx = r5_pa;
        n_mn = r5_pa;
        if (r5_pb > n_mx) n_mx = r5_pb;
        if (r5_pc > n_mx) n_mx = r5_pc;
        if (r5_pb < n_mn) n_mn = r5_pb;
        if (r5_pc < n_mn) n_mn = r5_pc;
    end

    always_ff @(posedge i_clk) begin
        if (n_en[6]) begin
            r6_pa <= r5_pa;
            r6_pb <= r5_pb;
            r6_pc <= r5_pc;
            r6_mm <= ipk_pkg::MM_W'(n_mx) + ipk_pkg::MM_W'(n_mn);
        end
    end

    // Stage 7: neutral shift at scale 2^17, round half up, saturate
    always_comb begin
        n_fa = (ipk_pkg::FIN_W'(r6_pa) <<< 1) - ipk_pkg::FIN_W'(r6_mm) + RND17;
        n_fb = (ipk_pkg::FIN_W'(r6_pb) <<< 1) - ipk_pkg::FIN_W'(r6_mm) + RND17;
        n_fc = (ipk_pkg::FIN_W'(r6_pc) <<< 1) - ipk_pkg::FIN_W'(r6_mm) + RND17;
        n_qa = ipk_pkg::Q_W'(n_fa >>> 17);
        n_qb = ipk_pkg::Q_W'(n_fb >>> 17);
        n_qc = ipk_pkg::Q_W'(n_fc >>> 17);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[7]) begin
            r_pha <= sat_volt(n_qa);
            r_phb <= sat_volt(n_qb);
            r_phc <= sat_volt(n_qc);
        end
    end

    assign o_out.valid   = r_vld[NSTG];
    assign o_out.phase_a = r_pha;
    assign o_out.phase_b = r_phb;
    assign o_out.phase_c = r_phc;

    // A held stage keeps its beat
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (($past(n_stall) & r_vld) == $past(n_stall)))
        else $error("stalled pipeline stage lost its beat");

    // Three balanced phases before the neutral shift sum to zero
    a_phase_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (SUM3_W'(r5_pa) + SUM3_W'(r5_pb) + SUM3_W'(r5_pc)) == '0)
        else $error("inverse Clarke phases do not sum to zero");

    // Max/min search ordering
    a_max_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (n_mx >= n_mn) && (n_mx >= r5_pb) && (n_mn <= r5_pc))
        else $error("phase max below phase min");

endmodule

>>> rtl/ipk_park.sv
// Sine/cosine lookup and inverse Park rotation, three register stages.
module ipk_park (
    input  logic                                  i_clk,
    input  ipk_pkg::t_park_ctl                    i_ctl,
    input  logic signed [ipk_pkg::VOLT_BITS-1:0]  i_volt_q,
    input  logic signed [ipk_pkg::VOLT_BITS-1:0]  i_volt_d,
    input  logic        [ipk_pkg::ANGLE_BITS-1:0] i_angle,
    output logic signed [ipk_pkg::ALPHA_W-1:0]    o_alpha,
    output logic signed [ipk_pkg::ALPHA_W-1:0]    o_beta
);

    localparam logic signed [ipk_pkg::SUM_W-1:0] RND14 = ipk_pkg::SUM_W'(1 << 13);

    logic [1:0]                      n_quad_s;
    logic [1:0]                      n_quad_c;
    logic [ipk_pkg::QTR_BITS-1:0]    n_rem;
    logic [ipk_pkg::IDX_W-1:0]       n_idx_s;
    logic [ipk_pkg::IDX_W-1:0]       n_idx_c;

    logic [ipk_pkg::ROM_W-1:0]               r_sin_mag;
    logic [ipk_pkg::ROM_W-1:0]               r_cos_mag;
    logic                                    r_sin_neg;
    logic                                    r_cos_neg;
    logic signed [ipk_pkg::VOLT_BITS-1:0]    r_vq1;
    logic signed [ipk_pkg::VOLT_BITS-1:0]    r_vd1;

    logic signed [ipk_pkg::SIN_W-1:0]        n_sin;
    logic signed [ipk_pkg::SIN_W-1:0]        n_cos;
    logic signed [ipk_pkg::PROD_W-1:0]       r_p_sq;
    logic signed [ipk_pkg::PROD_W-1:0]       r_p_cd;
    logic signed [ipk_pkg::PROD_W-1:0]       r_p_cq;
    logic signed [ipk_pkg::PROD_W-1:0]       r_p_sd;

    logic signed [ipk_pkg::SUM_W-1:0]        n_sum_a;
    logic signed [ipk_pkg::SUM_W-1:0]        n_sum_b;
    logic signed [ipk_pkg::ALPHA_W-1:0]      r_alpha;
    logic signed [ipk_pkg::ALPHA_W-1:0]      r_beta;

    // Table addresses: cosine is the sine a quarter turn on
    always_comb begin
        n_quad_s = i_angle[ipk_pkg::ANGLE_BITS-1 -: 2];
        n_quad_c = n_quad_s + 2'd1;
        n_rem    = i_angle[ipk_pkg::QTR_BITS-1:0];
        n_idx_s  = n_quad_s[0] ? ipk_pkg::IDX_W'(ipk_pkg::QUARTER) - {1'b0, n_rem}
                               : {1'b0, n_rem};
        n_idx_c  = n_quad_c[0] ? ipk_pkg::IDX_W'(ipk_pkg::QUARTER) - {1'b0, n_rem}
                               : {1'b0, n_rem};
    end

    // Stage 1: registered table read, two ports
    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_sin_mag <= ipk_pkg::SIN_ROM[n_idx_s];
            r_cos_mag <= ipk_pkg::SIN_ROM[n_idx_c];
            r_sin_neg <= n_quad_s[1];
            r_cos_neg <= n_quad_c[1];
            r_vq1     <= i_volt_q;
            r_vd1     <= i_volt_d;
        end
    end

    // Stage 2: apply quadrant sign, four products
    always_comb begin
        n_sin = r_sin_neg ? -ipk_pkg::SIN_W'(r_sin_mag) : ipk_pkg::SIN_W'(r_sin_mag);
        n_cos = r_cos_neg ? -ipk_pkg::SIN_W'(r_cos_mag) : ipk_pkg::SIN_W'(r_cos_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_p_sq <= n_sin * r_vq1;
            r_p_cd <= n_cos * r_vd1;
            r_p_cq <= n_cos * r_vq1;
            r_p_sd <= n_sin * r_vd1;
        end
    end

    // Stage 3: rotate and round half up to Q2.14
    always_comb begin
        n_sum_a = ipk_pkg::SUM_W'(r_p_cd) - ipk_pkg::SUM_W'(r_p_sq) + RND14;
        n_sum_b = ipk_pkg::SUM_W'(r_p_cq) + ipk_pkg::SUM_W'(r_p_sd) + RND14;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_alpha <= ipk_pkg::ALPHA_W'(n_sum_a >>> 14);
            r_beta  <= ipk_pkg::ALPHA_W'(n_sum_b >>> 14);
        end
    end

    assign o_alpha = r_alpha;
    assign o_beta  = r_beta;

endmodule

>>> dv/inverse_park_svpwm_test.sv
// Self-checking testbench for the inverse Park / Clarke / min-max injection block.
module inverse_park_svpwm_test;

    localparam int VOLT_W  = ipk_pkg::VOLT_BITS;
    localparam int ANGLE_W = ipk_pkg::ANGLE_BITS;

    localparam int QUARTER_STEPS = 1 << (ANGLE_W - 2);
    localparam int DIRECTED_COUNT = 24;
    localparam int RANDOM_ITEMS   = 1380;
    localparam int HOLD_OFF_AFTER = 400;
    localparam int HOLD_OFF_LEN   = 80;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_CAP     = 60;

    typedef longint unsigned u64_t;

    localparam u64_t QTR_TURN_Q30   = 64'd1686629713;
    localparam longint ROOT3_HALF_Q16 = 56756;

    // One command beat
    typedef struct packed {
        logic signed [VOLT_W-1:0]  volt_q;
        logic signed [VOLT_W-1:0]  volt_d;
        logic        [ANGLE_W-1:0] rotor_angle;
    } cmd_t;

    // Phase voltages, index 0 = a, 1 = b, 2 = c
    typedef logic [2:0][VOLT_W-1:0] phase_trio_t;

    // Directed row: known = 1 means the phases are given in the row
    typedef struct {
        int vq;
        int vd;
        int ang;
        bit known;
        int pa;
        int pb;
        int pc;
    } stim_row_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_THIRDS,
        SINK_SPARSE
    } sink_mode_e;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipk_in_if  cmd_if ();
    ipk_out_if ph_if ();

    inverse_park_svpwm uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (ph_if)
    );

    phase_trio_t pending_phases [$];
    longint      sine_q14 [QUARTER_STEPS + 1];
    int          cmds_taken  = 0;
    int          phase_faults = 0;
    int          cycle_count = 0;
    bit          hold_off    = 1'b0;
    string       phase_tag [3] = '{"a", "b", "c"};

    // Extremes, quadrant edges, zero commands and saturating vectors
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{0,      0,      0,    1'b1, 0,      0,      0},
        '{0,      0,      4095, 1'b1, 0,      0,      0},
        '{0,      16384,  0,    1'b1, 12288,  -12288, -12288},
        '{0,      -16384, 0,    1'b1, -12288, 12288,  12288},
        '{16384,  0,      1024, 1'b1, -12288, 12288,  12288},
        '{32767,  32767,  0,    1'b0, 0,      0,      0},
        '{-32768, -32768, 0,    1'b0, 0,      0,      0},
        '{32767,  -32768, 512,  1'b0, 0,      0,      0},
        '{-32768, 32767,  1536, 1'b0, 0,      0,      0},
        '{32767,  0,      1023, 1'b0, 0,      0,      0},
        '{32767,  0,      1024, 1'b0, 0,      0,      0},
        '{32767,  0,      1025, 1'b0, 0,      0,      0},
        '{-32768, 0,      2047, 1'b0, 0,      0,      0},
        '{-32768, 0,      2048, 1'b0, 0,      0,      0},
        '{0,      32767,  3071, 1'b0, 0,      0,      0},
        '{0,      32767,  3072, 1'b0, 0,      0,      0},
        '{0,      -32768, 4095, 1'b0, 0,      0,      0},
        '{32767,  32767,  2560, 1'b0, 0,      0,      0},
        '{-32768, 32767,  3584, 1'b0, 0,      0,      0},
        '{-1,     -1,     1,    1'b0, 0,      0,      0},
        '{1,      1,      2049, 1'b0, 0,      0,      0},
        '{12345,  -23456, 777,  1'b0, 0,      0,      0},
        '{-32768, -32768, 2048, 1'b0, 0,      0,      0},
        '{32767,  32767,  4095, 1'b0, 0,      0,      0}
    };

    // Clock and reset
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Quarter-wave sine entry: Q2.30 Taylor series rounded half up to Q1.14
    function automatic longint taylor_sine(int k);
        u64_t   x;
        u64_t   x2;
        u64_t   term;
        longint acc;
        int     n;
        x    = (QTR_TURN_Q30 * u64_t'(k) + u64_t'(QUARTER_STEPS / 2)) / u64_t'(QUARTER_STEPS);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return longint'((u64_t'(acc) + 64'd32768) >> 16);
    endfunction

    // Full-turn sine from the quarter table
    function automatic longint sine_at(int unsigned ang);
        int unsigned a;
        int unsigned quad;
        int unsigned r;
        longint      s;
        a    = ang & ((1 << ANGLE_W) - 1);
        quad = a >> (ANGLE_W - 2);
        r    = a & (QUARTER_STEPS - 1);
        s    = quad[0] ? sine_q14[QUARTER_STEPS - r] : sine_q14[r];
        return quad[1] ? -s : s;
    endfunction

    // Add half an LSB, then floor shift
    function automatic longint round_at(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic [VOLT_W-1:0] clamp_volt(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (VOLT_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            v = hi;
        end
        if (v < lo) begin
            v = lo;
        end
        return VOLT_W'(v);
    endfunction

    // Rotation, inverse Clarke and min-max neutral shift for one beat
    function automatic phase_trio_t svm_phases(cmd_t cmd);
        longint      vq;
        longint      vd;
        longint      s;
        longint      c;
        longint      alpha;
        longint      beta;
        longint      ph [3];
        longint      mx;
        longint      mn;
        phase_trio_t res;
        int          i;
        vq    = cmd.volt_q;
        vd    = cmd.volt_d;
        s     = sine_at(cmd.rotor_angle);
        c     = sine_at(int'(cmd.rotor_angle) + QUARTER_STEPS);
        alpha = round_at(-s * vq + c * vd, 14);
        beta  = round_at(c * vq + s * vd, 14);
        // phases at scale 2^16
        ph[0] = alpha * 65536;
        ph[1] = -alpha * 32768 + beta * ROOT3_HALF_Q16;
        ph[2] = -alpha * 32768 - beta * ROOT3_HALF_Q16;
        mx = ph[0];
        mn = ph[0];
        for (i = 1; i < 3; i++) begin
            if (ph[i] > mx) mx = ph[i];
            if (ph[i] < mn) mn = ph[i];
        end
        for (i = 0; i < 3; i++) begin
            res[i] = clamp_volt(round_at(2 * ph[i] - (mx + mn), 17));
        end
        return res;
    endfunction

    // Volt field: mostly full range, some extremes and some small values
    function automatic logic [VOLT_W-1:0] random_volt();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return {1'b0, {(VOLT_W-1){1'b1}}};
                    2:       return {1'b1, {(VOLT_W-1){1'b0}}};
                    3:       return '1;
                    default: return VOLT_W'(1);
                endcase
            end
            1:       return VOLT_W'(int'($urandom_range(0, 16384)) - 8192);
            default: return VOLT_W'($urandom);
        endcase
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t cmd;
        cmd.volt_q = random_volt();
        cmd.volt_d = random_volt();
        if ($urandom_range(0, 3) == 0) begin
            // close to a quadrant edge, wrapping at the top
            cmd.rotor_angle = ANGLE_W'(($urandom_range(0, 3) << (ANGLE_W - 2))
                                       + $urandom_range(0, 4) - 2);
        end else begin
            cmd.rotor_angle = ANGLE_W'($urandom);
        end
        return cmd;
    endfunction

    // Command sender: bursts of beats with random gaps
    initial begin : cmd_sender
        cmd_t        cmd;
        phase_trio_t want;
        int          burst_left;
        int          gap;
        int          idx;
        int          k;
        cmd_if.valid       <= 1'b0;
        cmd_if.volt_q      <= '0;
        cmd_if.volt_d      <= '0;
        cmd_if.rotor_angle <= '0;
        for (k = 0; k <= QUARTER_STEPS; k++) begin
            sine_q14[k] = taylor_sine(k);
        end
        do @(posedge i_clk); while (!i_rst_n);
        burst_left = 0;
        for (idx = 0; idx < DIRECTED_COUNT + RANDOM_ITEMS; idx++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    cmd_if.valid       <= 1'b0;
                    cmd_if.volt_q      <= VOLT_W'($urandom);
                    cmd_if.volt_d      <= VOLT_W'($urandom);
                    cmd_if.rotor_angle <= ANGLE_W'($urandom);
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 20);
            end
            burst_left--;
            if (idx < DIRECTED_COUNT) begin
                cmd.volt_q      = VOLT_W'(directed_rows[idx].vq);
                cmd.volt_d      = VOLT_W'(directed_rows[idx].vd);
                cmd.rotor_angle = ANGLE_W'(directed_rows[idx].ang);
                if (directed_rows[idx].known) begin
                    want = {VOLT_W'(directed_rows[idx].pc), VOLT_W'(directed_rows[idx].pb),
                            VOLT_W'(directed_rows[idx].pa)};
                end else begin
                    want = svm_phases(cmd);
                end
            end else begin
                cmd  = random_cmd();
                want = svm_phases(cmd);
            end
            cmd_if.valid       <= 1'b1;
            cmd_if.volt_q      <= cmd.volt_q;
            cmd_if.volt_d      <= cmd.volt_d;
            cmd_if.rotor_angle <= cmd.rotor_angle;
            do @(posedge i_clk); while (!cmd_if.ready);
            pending_phases.push_back(want);
            cmds_taken++;
        end
        cmd_if.valid <= 1'b0;

        // drain, then give the pipe time to show any stray beat
        while (pending_phases.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (phase_faults == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Long sink hold-off so the pipe fills and backs up onto the input
    initial begin : sink_hold
        do @(posedge i_clk); while (cmds_taken < HOLD_OFF_AFTER);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Phase sink: stall pattern switches to a random mode whenever a run ends
    initial begin : phase_sink
        sink_mode_e mode;
        int         mode_left;
        int         tick;
        bit         take;
        ph_if.ready <= 1'b0;
        mode      = SINK_OPEN;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = sink_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 250);
            end
            mode_left--;
            tick++;
            case (mode)
                SINK_OPEN:   take = 1'b1;
                SINK_COIN:   take = $urandom_range(0, 1) == 1;
                SINK_THIRDS: take = (tick % 3) != 0;
                default:     take = $urandom_range(0, 3) == 0;
            endcase
            ph_if.ready <= take && !hold_off;
        end
    end

    // Result check against the oldest outstanding beat
    always @(posedge i_clk) begin : phase_check
        phase_trio_t want;
        phase_trio_t got;
        int          i;
        if (i_rst_n && ph_if.valid && ph_if.ready) begin
            got = {ph_if.phase_c, ph_if.phase_b, ph_if.phase_a};
            if (pending_phases.size() == 0) begin
                phase_faults++;
                if (phase_faults <= REPORT_CAP) begin
                    $display("%0t: unexpected beat, expected none, got a=%0d b=%0d c=%0d",
                             $time, $signed(got[0]), $signed(got[1]), $signed(got[2]));
                end
            end else begin
                want = pending_phases.pop_front();
                for (i = 0; i < 3; i++) begin
                    if (got[i] !== want[i]) begin
                        phase_faults++;
                        if (phase_faults <= REPORT_CAP) begin
                            $display("%0t: phase %s expected %0d, got %0d", $time,
                                     phase_tag[i], $signed(want[i]), $signed(got[i]));
                        end
                    end
                end
            end
        end
    end

endmodule
